// ----- hdl/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// Beep pattern sequencer package
// Shared widths, item kinds and the result record of the beep sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int COUNT_W   = 8;
    localparam int UNITS_W   = 12;
    localparam int PERIOD_W  = 16;
    localparam int SCALE_W   = 10;
    localparam int PROD_W    = UNITS_W + SCALE_W;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 8;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

    typedef enum logic
    {
        FUNC_TICK    = 1'b0,
        FUNC_REQUEST = 1'b1
    } func_t;

    typedef struct packed
    {
        logic request_dropped;
        logic busy_res;
        logic buzzer_on;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ----- hdl/bps_out_queue.sv -----
// ----------------------------------------------------------------------------
// Beep sequencer result queue
// Two-entry output buffer that decouples the result stream from the input
// side; space is reported from a register.
// ----------------------------------------------------------------------------
module bps_out_queue
    import bps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    has_space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    head_reg;
    result_t    head_next;
    result_t    tail_reg;
    result_t    tail_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;
    assign has_space = (count_reg != 2'd2);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    head_next = push_data;
                end
                else
                begin
                    tail_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    head_next = push_data;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

// ----- hdl/beep_pattern_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Beep pattern sequencer core
// Buzzer beep sequencer driven by timer ticks and beep requests.
//
// Input stream (s_axis): tuser selects the transaction kind (0 tick,
// 1 beep request); tdata carries the beep count and duration in units.
// Output stream (m_axis): one result transaction per input transaction with
// the buzzer level, busy flag and a dropped-request flag.
// cfg_we/cfg_wdata write the buzzer enable bit; change it only while idle.
// The result is registered in the output queue before it is visible.
// Throughput: one transaction per cycle while the result queue has room;
// the state update for an item is done in the cycle it is accepted, and a
// two-entry result queue sits on the output side.
// Reset: pattern stopped, buffer slots empty, buzzer off, enable set.
// When the receiver stalls the queue fills; s_axis_tready drops once two
// results are waiting and rises again when one is taken.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer_core
    import bps_pkg::*;
#(
    parameter int TICKS_PER_UNIT = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // beep_count[7:0], duration_units[19:8]
    input  logic                  s_axis_tuser,   // func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // buzzer_on, busy_res, request_dropped
);

    logic                enable_reg;
    logic                running_reg;
    logic                running_next;
    logic                drive_reg;
    logic                drive_next;
    logic [COUNT_W-1:0]  beeps_reg;
    logic [COUNT_W-1:0]  beeps_next;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] period_next;
    logic [PERIOD_W-1:0] elapsed_reg;
    logic [PERIOD_W-1:0] elapsed_next;
    logic [1:0]          slot_valid_reg;
    logic [1:0]          slot_valid_next;
    logic [COUNT_W-1:0]  slot_count_reg [2];
    logic [COUNT_W-1:0]  slot_count_next [2];
    logic [PERIOD_W-1:0] slot_period_reg [2];
    logic [PERIOD_W-1:0] slot_period_next [2];

    logic                accept;
    func_t               func;
    logic [COUNT_W-1:0]  req_count;
    logic [UNITS_W-1:0]  req_units;
    logic [PROD_W-1:0]   req_product;
    logic [PERIOD_W-1:0] req_period;
    logic [PERIOD_W-1:0] elapsed_inc;
    logic                dropped;
    result_t             result;
    result_t             out_result;
    logic                queue_space;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign func      = func_t'(s_axis_tuser);
    assign req_count = s_axis_tdata[COUNT_W-1:0];
    assign req_units = s_axis_tdata[COUNT_W +: UNITS_W];

    assign req_product = PROD_W'(req_units) * PROD_W'(TICKS_PER_UNIT);
    assign req_period  = (req_product > PROD_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                             : req_product[PERIOD_W-1:0];
    assign elapsed_inc = (elapsed_reg == PERIOD_MAX) ? elapsed_reg
                                                     : elapsed_reg + PERIOD_W'(1);

    always_comb
    begin
        running_next     = running_reg;
        drive_next       = drive_reg;
        beeps_next       = beeps_reg;
        period_next      = period_reg;
        elapsed_next     = elapsed_reg;
        slot_valid_next  = slot_valid_reg;
        slot_count_next  = slot_count_reg;
        slot_period_next = slot_period_reg;
        dropped          = 1'b0;
        unique case (func)
            FUNC_REQUEST:
            begin
                if (enable_reg)
                begin
                    if (!running_reg)
                    begin
                        running_next = 1'b1;
                        beeps_next   = req_count;
                        period_next  = req_period;
                        drive_next   = 1'b1;
                    end
                    else if (!slot_valid_reg[0])
                    begin
                        slot_valid_next[0]  = 1'b1;
                        slot_count_next[0]  = req_count;
                        slot_period_next[0] = req_period;
                    end
                    else if (!slot_valid_reg[1])
                    begin
                        slot_valid_next[1]  = 1'b1;
                        slot_count_next[1]  = req_count;
                        slot_period_next[1] = req_period;
                    end
                    else
                    begin
                        dropped = 1'b1;
                    end
                end
            end
            FUNC_TICK:
            begin
                if (running_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= period_reg)
                    begin
                        elapsed_next = '0;
                        if (drive_reg)
                        begin
                            drive_next = 1'b0;
                            beeps_next = beeps_reg - COUNT_W'(1);
                        end
                        else if (beeps_reg != '0)
                        begin
                            drive_next = 1'b1;
                        end
                        else if (slot_valid_reg[0])
                        begin
                            slot_valid_next[0] = 1'b0;
                            beeps_next         = slot_count_reg[0];
                            period_next        = slot_period_reg[0];
                        end
                        else if (slot_valid_reg[1])
                        begin
                            slot_valid_next[1] = 1'b0;
                            beeps_next         = slot_count_reg[1];
                            period_next        = slot_period_reg[1];
                        end
                        else
                        begin
                            running_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                dropped = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.buzzer_on       = drive_next;
        result.busy_res        = running_next;
        result.request_dropped = dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg         <= 1'b1;
            running_reg        <= 1'b0;
            drive_reg          <= 1'b0;
            beeps_reg          <= '0;
            period_reg         <= '0;
            elapsed_reg        <= '0;
            slot_valid_reg     <= '0;
            slot_count_reg[0]  <= '0;
            slot_count_reg[1]  <= '0;
            slot_period_reg[0] <= '0;
            slot_period_reg[1] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            if (accept)
            begin
                running_reg     <= running_next;
                drive_reg       <= drive_next;
                beeps_reg       <= beeps_next;
                period_reg      <= period_next;
                elapsed_reg     <= elapsed_next;
                slot_valid_reg  <= slot_valid_next;
                slot_count_reg  <= slot_count_next;
                slot_period_reg <= slot_period_next;
            end
        end
    end

    bps_out_queue u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .has_space (queue_space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign s_axis_tready = queue_space;
    assign m_axis_tdata  = OUT_DATA_W'(out_result);

    assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> !drive_reg)
        else $error("buzzer driven while no pattern runs");

    assert property (@(posedge clk) disable iff (!rst_n)
        (slot_valid_reg != 2'b00) |-> running_reg)
        else $error("buffered request held while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_TICK && !running_reg) |=>
            ($stable(beeps_reg) && $stable(elapsed_reg) && !running_reg))
        else $error("idle tick changed the pattern state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_REQUEST && !enable_reg) |=>
            ($stable(slot_valid_reg) && $stable(running_reg)))
        else $error("disabled request altered the sequencer");

endmodule
